// File: rtl/ambient_compensated_optical_level_sense_assert.svh
// Assertion macros for the optical level sense RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef AMBIENT_COMPENSATED_OPTICAL_LEVEL_SENSE_ASSERT_SVH
`define AMBIENT_COMPENSATED_OPTICAL_LEVEL_SENSE_ASSERT_SVH

`ifndef SYNTH
// Property checked every clock, masked during reset.
`define ACOLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked every clock, including reset cycles.
`define ACOLS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ACOLS_ASSERT(lbl, prop, msg)
`define ACOLS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/acols_pkg.sv
// Shared types and constants for the optical level sense block.
// No dependencies.
`timescale 1ns / 1ps

package acols_pkg;

  localparam int ADC_BITS     = 12;
  localparam int SAMPLE_COUNT = 5;

  localparam int THRESH_W   = ADC_BITS;
  localparam int SETTLE_W   = 16;
  localparam int GAP_W      = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_SETTLE    = 2'd1,
    CFG_GAP       = 2'd2,
    CFG_SIMULATE  = 2'd3
  } cfg_idx_t;

  localparam logic [THRESH_W-1:0] THRESHOLD_RST = THRESH_W'(200);
  localparam logic [SETTLE_W-1:0] SETTLE_RST    = SETTLE_W'(500);
  localparam logic [GAP_W-1:0]    GAP_RST       = GAP_W'(2);

  localparam logic ACT_TRIGGER = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  typedef struct packed {
    logic                action;
    logic [ADC_BITS-1:0] adc_value;
  } in_item_t;

  typedef struct packed {
    logic laser_enable;
    logic busy_res;
    logic filled;
    logic done_res;
  } out_item_t;

endpackage

// File: rtl/ambient_compensated_optical_level_sense.sv
// Top level of the ambient-compensated optical level sense block.
// Depends on acols_pkg and ambient_compensated_optical_level_sense_assert.svh.
`timescale 1ns / 1ps

// Usage:
//   in_*  : one request per trigger (action 0) or millisecond tick (action 1)
//           carrying the current detector sample.
//   out_* : exactly one result per request, in order: emitter drive, busy,
//           filled decision and a done pulse on the tick that ends a measurement.
//   cfg_* : register writes (threshold, settle, sample gap, simulate), taken
//           at any edge with cfg_we high; write only while the block is idle.
// A request passes an input register, then the state update that loads
// the result register. One request is taken per cycle while the result
// register is not stalled; each takes a single pass through the sequencer
// (incrementer, sample adder, reciprocal multiply and threshold compare).
// A stalled result holds in the result register; one request may still enter
// the input register, after which in_ready follows out_ready.
// Reset is synchronous: registers return to 200 / 500 / 2 / off, the
// sequencer to idle with cleared accumulators, and both channels empty.
module ambient_compensated_optical_level_sense
  import acols_pkg::*;
#(
  parameter int SAMPLE_COUNT_P = SAMPLE_COUNT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "ambient_compensated_optical_level_sense_assert.svh"

  localparam int LOG_N   = $clog2(SAMPLE_COUNT_P);
  localparam int SUM_W   = ADC_BITS + LOG_N;
  localparam int CNT_W   = $clog2(SAMPLE_COUNT_P + 1);
  // x / N == (x * RECIP) >> SHIFT for every x below 2**SUM_W
  localparam int SHIFT   = SUM_W + LOG_N;
  localparam int RECIP_W = SUM_W + 1;
  localparam longint RECIP_L = ((64'(1) << SHIFT) + SAMPLE_COUNT_P - 1) / SAMPLE_COUNT_P;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int PROD_W  = SUM_W + RECIP_W;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_AMBIENT,
    PH_LIT_WAIT,
    PH_SAMPLING
  } phase_t;

  // configuration
  logic [THRESH_W-1:0] threshold_r;
  logic [SETTLE_W-1:0] settle_r;
  logic [GAP_W-1:0]    gap_r;
  logic                simulate_r;

  // input register
  logic     s1_valid_r;
  in_item_t s1_data_r;

  // sequencer state
  phase_t              phase_r, phase_nxt;
  logic [SETTLE_W-1:0] elapsed_r, elapsed_nxt;
  logic [ADC_BITS-1:0] ambient_r, ambient_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                blocked_r, blocked_nxt;
  logic                out_valid_r;
  out_item_t           out_data_r, out_data_nxt;

  logic                advance;
  logic [SETTLE_W-1:0] elapsed_inc;
  logic                settle_hit, gap_hit;
  logic [SUM_W-1:0]    base_sum, sum_add;
  logic [CNT_W-1:0]    base_cnt, cnt_add;
  logic [PROD_W-1:0]   prod;
  logic [ADC_BITS-1:0] avg, delta;
  logic                last_sample;
  logic                done;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      settle_r    <= SETTLE_RST;
      gap_r       <= GAP_RST;
      simulate_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD: threshold_r <= cfg_data[THRESH_W-1:0];
        CFG_SETTLE:    settle_r    <= cfg_data[SETTLE_W-1:0];
        CFG_GAP:       gap_r       <= cfg_data[GAP_W-1:0];
        CFG_SIMULATE:  simulate_r  <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // shared datapath: wait counter, sample accumulation, average and ambient difference
  always_comb begin
    elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + SETTLE_W'(1);
    settle_hit  = elapsed_inc >= settle_r;
    gap_hit     = elapsed_inc >= SETTLE_W'(gap_r);
    // first lit sample restarts the accumulator
    base_sum    = (phase_r == PH_LIT_WAIT) ? '0 : sum_r;
    base_cnt    = (phase_r == PH_LIT_WAIT) ? '0 : cnt_r;
    sum_add     = base_sum + SUM_W'(s1_data_r.adc_value);
    cnt_add     = base_cnt + CNT_W'(1);
    last_sample = cnt_add >= CNT_W'(SAMPLE_COUNT_P);
    prod        = PROD_W'(sum_add) * PROD_W'(RECIP);
    avg         = prod[SHIFT +: ADC_BITS];
    delta       = (avg >= ambient_r) ? avg - ambient_r : ambient_r - avg;
  end

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    ambient_nxt = ambient_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    blocked_nxt = blocked_r;
    done        = 1'b0;

    if (!simulate_r) begin
      if (s1_data_r.action == ACT_TRIGGER) begin
        if (phase_r == PH_IDLE) begin
          elapsed_nxt = '0;
          phase_nxt   = PH_AMBIENT;
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: ;
          PH_AMBIENT: begin
            elapsed_nxt = elapsed_inc;
            if (settle_hit) begin
              ambient_nxt = s1_data_r.adc_value;
              elapsed_nxt = '0;
              phase_nxt   = PH_LIT_WAIT;
            end
          end
          PH_LIT_WAIT, PH_SAMPLING: begin
            elapsed_nxt = elapsed_inc;
            if ((phase_r == PH_LIT_WAIT) ? settle_hit : gap_hit) begin
              sum_nxt     = sum_add;
              cnt_nxt     = cnt_add;
              elapsed_nxt = '0;
              phase_nxt   = PH_SAMPLING;
              if (last_sample) begin
                blocked_nxt = delta < threshold_r;
                phase_nxt   = PH_IDLE;
                done        = 1'b1;
              end
            end
          end
        endcase
      end
    end

    out_data_nxt.laser_enable = (phase_nxt == PH_LIT_WAIT) || (phase_nxt == PH_SAMPLING);
    out_data_nxt.busy_res     = phase_nxt != PH_IDLE;
    out_data_nxt.filled       = simulate_r || blocked_nxt;
    out_data_nxt.done_res     = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      elapsed_r   <= '0;
      ambient_r   <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      blocked_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      if (advance) begin
        phase_r    <= phase_nxt;
        elapsed_r  <= elapsed_nxt;
        ambient_r  <= ambient_nxt;
        sum_r      <= sum_nxt;
        cnt_r      <= cnt_nxt;
        blocked_r  <= blocked_nxt;
        out_data_r <= out_data_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `ACOLS_ASSERT(a_done_ends_measurement, out_valid_r && out_data_r.done_res |-> !out_data_r.busy_res && !out_data_r.laser_enable, "done reported while still busy")
  `ACOLS_ASSERT(a_count_in_range, cnt_r <= CNT_W'(SAMPLE_COUNT_P), "sample count out of range")
  `ACOLS_ASSERT(a_no_overrun, s1_valid_r && out_valid_r && !out_ready |-> !in_ready, "input taken while both stages are stalled")
  `ACOLS_ASSERT(a_sim_freezes, simulate_r && advance |=> phase_r == $past(phase_r) && sum_r == $past(sum_r), "state moved in simulation mode")
  `ACOLS_ASSERT(a_start_needs_trigger, phase_r == PH_IDLE && !(advance && s1_data_r.action == ACT_TRIGGER) |=> phase_r == PH_IDLE, "left idle without a trigger")
  `ACOLS_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid_r && !s1_valid_r, "channel not empty after reset")

endmodule
